### src/pta_pkg.sv
// pta_pkg: shared types and constants of the primitive-to-triangle assembler
// no dependencies
`timescale 1ns / 1ps

package pta_pkg;

   localparam logic       CMD_START  = 1'b0;
   localparam logic       CMD_INDEX  = 1'b1;

   localparam logic [3:0] TYPE_LIST  = 4'd4;
   localparam logic [3:0] TYPE_STRIP = 4'd5;
   localparam logic [3:0] TYPE_FAN   = 4'd6;
   localparam logic [3:0] TYPE_QUADS = 4'd7;

   typedef struct packed {
      logic        cmd;
      logic [3:0]  prim_type;
      logic [15:0] prim_count;
      logic [15:0] vertex_index;
   } req_type;

   typedef struct packed {
      logic [31:0] corner_a;
      logic [31:0] corner_b;
      logic [31:0] corner_c;
      logic        last;
   } rsp_type;

   // one closed primitive: a triangle (a,b,c) or a quad giving (a,b,c) and (a,c,d)
   typedef struct packed {
      logic [15:0] idx_a;
      logic [15:0] idx_b;
      logic [15:0] idx_c;
      logic [15:0] idx_d;
      logic        quad;
   } job_type;

   typedef struct packed {
      logic second_pending;
      logic out_valid;
   } back_status_type;

endpackage

### src/pta_front.sv
// pta_front: accepts request transactions, tracks group state, closes primitives
// depends on pta_pkg
`timescale 1ns / 1ps

module pta_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  pta_pkg::req_type req_data,
   input  logic             q_full,
   output logic             q_push,
   output pta_pkg::job_type q_data
);

   logic [3:0]  group_type_ff, group_type_in;
   logic [15:0] prims_left_ff, prims_left_in;
   logic [1:0]  slot_ff, slot_in;
   logic        parity_ff, parity_in;
   logic [15:0] held_ff [3];
   logic [15:0] held_in [3];
   logic        accept;
   logic        emit;
   logic [15:0] v;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign v        = req_data.vertex_index;

   always_comb begin
      group_type_in = group_type_ff;
      prims_left_in = prims_left_ff;
      slot_in       = slot_ff;
      parity_in     = parity_ff;
      held_in       = held_ff;
      emit          = 1'b0;
      q_data.idx_a  = held_ff[0];
      q_data.idx_b  = held_ff[1];
      q_data.idx_c  = v;
      q_data.idx_d  = v;
      q_data.quad   = 1'b0;
      if (accept) begin
         if (req_data.cmd == pta_pkg::CMD_START) begin
            group_type_in = req_data.prim_type;
            prims_left_in = req_data.prim_count;
            slot_in       = 2'd0;
            parity_in     = 1'b0;
         end else if (prims_left_ff != 16'd0) begin
            case (group_type_ff)
               pta_pkg::TYPE_LIST, pta_pkg::TYPE_STRIP, pta_pkg::TYPE_FAN: begin
                  if (slot_ff < 2'd2) begin
                     held_in[slot_ff] = v;
                     slot_in          = slot_ff + 2'd1;
                  end else begin
                     emit          = 1'b1;
                     prims_left_in = prims_left_ff - 16'd1;
                     if (group_type_ff == pta_pkg::TYPE_LIST) begin
                        slot_in = 2'd0;
                     end else if (group_type_ff == pta_pkg::TYPE_STRIP) begin
                        if (parity_ff) begin
                           q_data.idx_a = held_ff[1];
                           q_data.idx_b = held_ff[0];
                        end
                        held_in[0] = held_ff[1];
                        held_in[1] = v;
                        parity_in  = !parity_ff;
                     end else begin
                        held_in[1] = v;
                     end
                  end
               end
               pta_pkg::TYPE_QUADS: begin
                  if (slot_ff < 2'd3) begin
                     held_in[slot_ff] = v;
                     slot_in          = slot_ff + 2'd1;
                  end else begin
                     emit          = 1'b1;
                     q_data.idx_c  = held_ff[2];
                     q_data.quad   = 1'b1;
                     slot_in       = 2'd0;
                     prims_left_in = prims_left_ff - 16'd1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign q_push = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         group_type_ff <= 4'd0;
         prims_left_ff <= 16'd0;
         slot_ff       <= 2'd0;
         parity_ff     <= 1'b0;
      end else begin
         group_type_ff <= group_type_in;
         prims_left_ff <= prims_left_in;
         slot_ff       <= slot_in;
         parity_ff     <= parity_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

### src/pta_queue.sv
// pta_queue: short first-in first-out queue of closed primitives
// depends on pta_pkg
`timescale 1ns / 1ps

module pta_queue #(
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  pta_pkg::job_type             push_data,
   output logic                         full,
   input  logic                         pop,
   output pta_pkg::job_type             pop_data,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   pta_pkg::job_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/pta_back.sv
// pta_back: expands queued primitives into triangles, adds base vertex, output register
// depends on pta_pkg
`timescale 1ns / 1ps

module pta_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [31:0]              base_vertex,
   input  pta_pkg::job_type         q_data,
   input  logic                     q_empty,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output pta_pkg::rsp_type         rsp_data,
   output pta_pkg::back_status_type status
);

   logic             out_valid_ff, out_valid_in;
   pta_pkg::rsp_type out_ff, out_in;
   logic             pend_ff, pend_in;
   logic [15:0]      pend_a_ff, pend_a_in;
   logic [15:0]      pend_c_ff, pend_c_in;
   logic [15:0]      pend_d_ff, pend_d_in;
   logic             advance;
   logic [15:0]      sel_a, sel_b, sel_c;
   logic             sel_last;

   assign advance = !out_valid_ff || rsp_pop;
   assign q_pop   = advance && !pend_ff && !q_empty;

   always_comb begin
      if (pend_ff) begin
         sel_a    = pend_a_ff;
         sel_b    = pend_c_ff;
         sel_c    = pend_d_ff;
         sel_last = 1'b1;
      end else begin
         sel_a    = q_data.idx_a;
         sel_b    = q_data.idx_b;
         sel_c    = q_data.idx_c;
         sel_last = !q_data.quad;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      pend_in      = pend_ff;
      pend_a_in    = pend_a_ff;
      pend_c_in    = pend_c_ff;
      pend_d_in    = pend_d_ff;
      if (advance) begin
         out_in.corner_a = base_vertex + {16'd0, sel_a};
         out_in.corner_b = base_vertex + {16'd0, sel_b};
         out_in.corner_c = base_vertex + {16'd0, sel_c};
         out_in.last     = sel_last;
         if (pend_ff) begin
            out_valid_in = 1'b1;
            pend_in      = 1'b0;
         end else if (!q_empty) begin
            out_valid_in = 1'b1;
            pend_in      = q_data.quad;
            pend_a_in    = q_data.idx_a;
            pend_c_in    = q_data.idx_c;
            pend_d_in    = q_data.idx_d;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff    <= out_in;
      pend_a_ff <= pend_a_in;
      pend_c_ff <= pend_c_in;
      pend_d_ff <= pend_d_in;
   end

   assign rsp_empty             = !out_valid_ff;
   assign rsp_data              = out_ff;
   assign status.second_pending = pend_ff;
   assign status.out_valid      = out_valid_ff;

endmodule

### src/primitive_to_triangle_assembler_top.sv
// primitive_to_triangle_assembler_top: top level, base vertex register and assertions
// depends on pta_pkg, pta_front, pta_queue, pta_back
`timescale 1ns / 1ps

// Turns start commands and vertex indices into triangles with base_vertex added.
// One request transaction is taken every cycle while req_full is low; req_full rises
// only when the primitive queue (QUEUE_DEPTH entries) is full. An index that closes a
// primitive passes the queue and then the output register before its triangle shows on
// rsp_data. The result stage sends one triangle per cycle while the output is empty
// or popped, so a quad takes two output slots and the queue absorbs those bursts.
// csr_ready is always high; write base_vertex only while the block is idle.

module primitive_to_triangle_assembler_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  pta_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output pta_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

   logic [31:0]              base_vertex_ff;
   logic                     q_push, q_pop, q_full, q_empty;
   pta_pkg::job_type         q_wr_data, q_rd_data;
   logic [CNT_W-1:0]         q_count;
   pta_pkg::back_status_type back_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_vertex_ff <= 32'd0;
      end else if (csr_valid && csr_ready) begin
         base_vertex_ff <= csr_data;
      end
   end

   pta_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wr_data)
   );

   pta_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .empty     (q_empty),
      .count     (q_count)
   );

   pta_back u_back (
      .clock       (clock),
      .reset       (reset),
      .base_vertex (base_vertex_ff),
      .q_data      (q_rd_data),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .status      (back_status)
   );

   // first half of a quad is on the output while the second waits
   a_pend_first_half: assert property (@(posedge clock) disable iff (reset)
      back_status.second_pending |-> (back_status.out_valid && !rsp_data.last))
      else $error("second triangle pending without first half on output");

   // a pending second triangle is always delivered next after a pop
   a_pend_delivered: assert property (@(posedge clock) disable iff (reset)
      (back_status.second_pending && rsp_pop) |=> (!rsp_empty && rsp_data.last))
      else $error("second triangle of quad not delivered after pop");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (q_count <= CNT_W'(QUEUE_DEPTH)) && !(q_push && q_full) && !(q_pop && q_empty))
      else $error("primitive queue overflow or underflow");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !back_status.second_pending))
      else $error("output not empty after reset");

endmodule
